@@ hw/rtl/vpma_pkg.sv @@
package vpma_pkg;

  localparam int unsigned AddrW    = 20;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 8;
  localparam int unsigned Planes   = 4;
  localparam int unsigned WordW    = 32;

  localparam logic [CfgIdxW-1:0] CFG_MISC_CONTROL     = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_GRAPHICS_MODE    = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_READ_PLANE       = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_ROTATE_AND_LOGIC = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_SET_RESET        = 3'd4;
  localparam logic [CfgIdxW-1:0] CFG_BIT_MASK         = 3'd5;
  localparam logic [CfgIdxW-1:0] CFG_PLANE_WRITE_MASK = 3'd6;
  localparam logic [CfgIdxW-1:0] CFG_MEMORY_MODE      = 3'd7;

  localparam logic [1:0] WMODE_ROTATE = 2'd0;
  localparam logic [1:0] WMODE_LATCH  = 2'd1;
  localparam logic [1:0] WMODE_EXPAND = 2'd2;
  localparam logic [1:0] WMODE_NONE   = 2'd3;

  localparam logic [1:0] LOGIC_COPY = 2'd0;
  localparam logic [1:0] LOGIC_AND  = 2'd1;
  localparam logic [1:0] LOGIC_OR   = 2'd2;
  localparam logic [1:0] LOGIC_XOR  = 2'd3;

  localparam logic MODE_READ  = 1'b0;
  localparam logic MODE_WRITE = 1'b1;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_ACCESS
  } vpma_state_e;

  typedef struct packed {
    logic clear_we;
    logic issue;
    logic commit;
  } vpma_ctrl_t;

endpackage

@@ hw/rtl/vpma_if.sv @@
interface vpma_req_if;
  import vpma_pkg::*;

  logic             valid;
  logic             ready;
  logic             mode;
  logic [AddrW-1:0] host_address;
  logic [7:0]       write_data;

  modport source (output valid, mode, host_address, write_data, input ready);
  modport sink (input valid, mode, host_address, write_data, output ready);
endinterface

interface vpma_rsp_if;
  logic       valid;
  logic       ready;
  logic [7:0] read_data;

  modport source (output valid, read_data, input ready);
  modport sink (input valid, read_data, output ready);
endinterface

@@ hw/rtl/vpma_ram.sv @@
module vpma_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 65536
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ hw/rtl/vpma_ctrl.sv @@
module vpma_ctrl import vpma_pkg::*; #(
  parameter int unsigned AddrBits = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                req_valid_i,
  output logic                req_ready_o,
  output logic                rsp_valid_o,
  input  logic                rsp_ready_i,
  output vpma_ctrl_t          ctl_o,
  output logic [AddrBits-1:0] clr_addr_o
);

  vpma_state_e         state_q, state_d;
  logic [AddrBits-1:0] clr_cnt_q, clr_cnt_d;
  logic                rsp_valid_q, rsp_valid_d;
  logic                req_ready;
  logic                clr_done;

  assign clr_done = &clr_cnt_q;

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_CLEAR: begin
        if (clr_done) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (req_valid_i && req_ready) begin
          state_d = S_ACCESS;
        end
      end
      S_ACCESS: state_d = S_IDLE;
      default:  state_d = S_CLEAR;
    endcase
  end

  always_comb begin
    req_ready      = (state_q == S_IDLE) && (!rsp_valid_q || rsp_ready_i);
    ctl_o.clear_we = (state_q == S_CLEAR);
    ctl_o.issue    = req_valid_i && req_ready;
    ctl_o.commit   = (state_q == S_ACCESS);
    clr_cnt_d      = (state_q == S_CLEAR) ? clr_cnt_q + 1'b1 : clr_cnt_q;
    if (state_q == S_ACCESS) begin
      rsp_valid_d = 1'b1;
    end else if (rsp_ready_i) begin
      rsp_valid_d = 1'b0;
    end else begin
      rsp_valid_d = rsp_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_cnt_q   <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_cnt_q   <= clr_cnt_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  assign req_ready_o = req_ready;
  assign rsp_valid_o = rsp_valid_q;
  assign clr_addr_o  = clr_cnt_q;

  a_no_accept_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CLEAR) |-> !req_ready)
    else $error("item accepted during the clearing pass");

  a_accept_then_access: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_valid_i && req_ready) |=> (state_q == S_ACCESS))
    else $error("accepted beat did not reach the access cycle");

  a_rsp_from_access: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rsp_valid_q) |-> $past(state_q == S_ACCESS))
    else $error("result appeared without an access cycle");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_ACCESS) |-> (!rsp_valid_q || rsp_ready_i))
    else $error("pending result would be overwritten");

endmodule

@@ hw/rtl/vpma_datapath.sv @@
module vpma_datapath import vpma_pkg::*; #(
  parameter int unsigned AddrBits = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic                req_mode_i,
  input  logic [AddrW-1:0]    req_addr_i,
  input  logic [7:0]          req_wdata_i,
  input  vpma_ctrl_t          ctl_i,
  input  logic [AddrBits-1:0] clr_addr_i,
  output logic                ram_we_o,
  output logic [AddrBits-1:0] ram_addr_o,
  output logic [WordW-1:0]    ram_wdata_o,
  input  logic [WordW-1:0]    ram_rdata_i,
  output logic [7:0]          read_data_o
);

  logic [7:0] misc_q, gmode_q, srr_q, bmask_q, memmode_q;
  logic [1:0] rplane_q;
  logic [4:0] rotlog_q;
  logic [3:0] pwmask_q;

  logic                mode_q;
  logic [1:0]          alow_q;
  logic [7:0]          wdata_q;
  logic [AddrBits-1:0] idx_q;
  logic [WordW-1:0]    latch_q, latch_d;
  logic [7:0]          rdata_q, rdata_d;

  logic [15:0]         off, off_chain, off_sel;
  logic [AddrBits-1:0] req_idx;
  logic [WordW-1:0]    new_word;
  logic [1:0]          rplane;

  always_comb begin
    off = req_addr_i[15:0];
    if (misc_q[3]) begin
      off[15] = 1'b0;
    end
    off_chain = off;
    if (misc_q[1]) begin
      off_chain[0] = (misc_q[3:2] == 2'd0) ? req_addr_i[16] : 1'b0;
    end
    off_sel = off_chain;
    if (req_mode_i == MODE_WRITE && memmode_q[3]) begin
      off_sel = {off[15:2], 2'b00};
    end
    req_idx = off_sel[AddrBits-1:0];
  end

  always_comb begin
    logic [15:0] rot2;
    logic [7:0]  rot;
    logic [7:0]  latch;
    logic [7:0]  pd;
    logic [7:0]  res;
    logic        en;
    rot2     = {wdata_q, wdata_q} >> rotlog_q[2:0];
    rot      = rot2[7:0];
    new_word = ram_rdata_i;
    for (int i = 0; i < Planes; i++) begin
      latch = latch_q[8*i +: 8];
      en    = pwmask_q[i]
              && (!gmode_q[4] || (i[0] == alow_q[0]))
              && (!memmode_q[3] || (i[1:0] == alow_q))
              && (gmode_q[1:0] != WMODE_NONE);
      if (gmode_q[1:0] == WMODE_EXPAND) begin
        pd = {8{wdata_q[i]}};
      end else if (srr_q[4+i]) begin
        pd = {8{srr_q[i]}};
      end else begin
        pd = rot;
      end
      case (rotlog_q[4:3])
        LOGIC_AND: pd = pd & latch;
        LOGIC_OR:  pd = pd | latch;
        LOGIC_XOR: pd = pd ^ latch;
        default:   pd = pd;
      endcase
      res = (pd & bmask_q) | (latch & ~bmask_q);
      if (gmode_q[1:0] == WMODE_LATCH) begin
        res = latch;
      end
      if (en) begin
        new_word[8*i +: 8] = res;
      end
    end
  end

  always_comb begin
    rplane  = rplane_q | {1'b0, gmode_q[4] & alow_q[0]};
    latch_d = latch_q;
    rdata_d = rdata_q;
    if (ctl_i.commit) begin
      if (mode_q == MODE_READ) begin
        latch_d = ram_rdata_i;
        rdata_d = ram_rdata_i[8*rplane +: 8];
      end else begin
        rdata_d = 8'h00;
      end
    end
  end

  always_comb begin
    ram_we_o    = ctl_i.clear_we || (ctl_i.commit && (mode_q == MODE_WRITE));
    ram_wdata_o = ctl_i.clear_we ? '0 : new_word;
    if (ctl_i.clear_we) begin
      ram_addr_o = clr_addr_i;
    end else if (ctl_i.commit) begin
      ram_addr_o = idx_q;
    end else begin
      ram_addr_o = req_idx;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      misc_q    <= 8'h00;
      gmode_q   <= 8'h00;
      rplane_q  <= 2'd0;
      rotlog_q  <= 5'd0;
      srr_q     <= 8'h00;
      bmask_q   <= 8'hFF;
      pwmask_q  <= 4'hF;
      memmode_q <= 8'h00;
      latch_q   <= '0;
    end else begin
      latch_q <= latch_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_MISC_CONTROL:     misc_q    <= cfg_data_i;
          CFG_GRAPHICS_MODE:    gmode_q   <= cfg_data_i;
          CFG_READ_PLANE:       rplane_q  <= cfg_data_i[1:0];
          CFG_ROTATE_AND_LOGIC: rotlog_q  <= cfg_data_i[4:0];
          CFG_SET_RESET:        srr_q     <= cfg_data_i;
          CFG_BIT_MASK:         bmask_q   <= cfg_data_i;
          CFG_PLANE_WRITE_MASK: pwmask_q  <= cfg_data_i[3:0];
          CFG_MEMORY_MODE:      memmode_q <= cfg_data_i;
          default:              misc_q    <= misc_q;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= rdata_d;
    if (ctl_i.issue) begin
      mode_q  <= req_mode_i;
      alow_q  <= req_addr_i[1:0];
      wdata_q <= req_wdata_i;
      idx_q   <= req_idx;
    end
  end

  assign read_data_o = rdata_q;

endmodule

@@ hw/rtl/vga_planar_memory_access.sv @@
// Host byte access into four video planes held side by side in one 32-bit word per offset
// of a single-port RAM. Every beat, read or write, has two steps: one reads the plane word
// from the RAM, the next returns the byte or writes the merged word back; a new beat is only
// taken once the last has finished, and while the result register is free or being emptied.
// After reset the RAM is cleared one word a cycle, all 2**PLANE_ADDR_BITS words, and no beat
// is accepted until that is done; configuration writes are taken at any time.
module vga_planar_memory_access import vpma_pkg::*; #(
  parameter int unsigned PLANE_ADDR_BITS = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  vpma_req_if.sink            req_i,
  vpma_rsp_if.source          rsp_o
);

  vpma_ctrl_t                 ctl;
  logic [PLANE_ADDR_BITS-1:0] clr_addr;
  logic                       ram_we;
  logic [PLANE_ADDR_BITS-1:0] ram_addr;
  logic [WordW-1:0]           ram_wdata;
  logic [WordW-1:0]           ram_rdata;

  vpma_ctrl #(
    .AddrBits(PLANE_ADDR_BITS)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_valid_i(req_i.valid),
    .req_ready_o(req_i.ready),
    .rsp_valid_o(rsp_o.valid),
    .rsp_ready_i(rsp_o.ready),
    .ctl_o      (ctl),
    .clr_addr_o (clr_addr)
  );

  vpma_datapath #(
    .AddrBits(PLANE_ADDR_BITS)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .req_mode_i (req_i.mode),
    .req_addr_i (req_i.host_address),
    .req_wdata_i(req_i.write_data),
    .ctl_i      (ctl),
    .clr_addr_i (clr_addr),
    .ram_we_o   (ram_we),
    .ram_addr_o (ram_addr),
    .ram_wdata_o(ram_wdata),
    .ram_rdata_i(ram_rdata),
    .read_data_o(rsp_o.read_data)
  );

  vpma_ram #(
    .Width(WordW),
    .Depth(2 ** PLANE_ADDR_BITS)
  ) u_planes (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .addr_i (ram_addr),
    .wdata_i(ram_wdata),
    .rdata_o(ram_rdata)
  );

endmodule

@@ tb/vga_planar_memory_access_tb.sv @@
module vga_planar_memory_access_tb;
  import vpma_pkg::*;

  localparam int unsigned PlaneAddrBits = 16;
  localparam int unsigned PlaneDepth    = 1 << PlaneAddrBits;
  localparam int unsigned WatchdogLimit = 300000;
  localparam int unsigned PhaseBeats    = 50;
  localparam int unsigned RandomPhases  = 16;

  class plane_scoreboard;
    bit [WordW-1:0] planes [PlaneDepth];
    bit [WordW-1:0] latches;
    bit [7:0]       misc_control;
    bit [7:0]       graphics_mode;
    bit [1:0]       read_plane;
    bit [4:0]       rotate_and_logic;
    bit [7:0]       set_reset;
    bit [7:0]       bit_mask;
    bit [3:0]       write_mask;
    bit [7:0]       memory_mode;
    bit [7:0]       expected_bytes [$];
    int             errors;
    int             reads;
    int             writes;

    function new();
      bit_mask   = 8'hFF;
      write_mask = 4'hF;
    endfunction

    function void set_register(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] value);
      case (idx)
        CFG_MISC_CONTROL:     misc_control     = value;
        CFG_GRAPHICS_MODE:    graphics_mode    = value;
        CFG_READ_PLANE:       read_plane       = value[1:0];
        CFG_ROTATE_AND_LOGIC: rotate_and_logic = value[4:0];
        CFG_SET_RESET:        set_reset        = value;
        CFG_BIT_MASK:         bit_mask         = value;
        CFG_PLANE_WRITE_MASK: write_mask       = value[3:0];
        CFG_MEMORY_MODE:      memory_mode      = value;
        default: ;
      endcase
    endfunction

    function bit [15:0] chained(bit [15:0] off, bit [AddrW-1:0] addr);
      if (misc_control[1]) begin
        if (misc_control[3:2] == 2'd0) off[0] = addr[16];
        else off[0] = 1'b0;
      end
      return off;
    endfunction

    function bit [7:0] predict_access(bit is_write, bit [AddrW-1:0] addr, bit [7:0] data);
      bit [15:0]              off;
      bit [PlaneAddrBits-1:0] idx;
      bit [WordW-1:0]         word;
      bit [7:0]               latch;
      bit [7:0]               pd;
      bit [7:0]               res;
      bit [15:0]              doubled;
      bit [1:0]               plane;
      bit [1:0]               wmode;
      bit [1:0]               op;
      bit                     odd_even;
      bit                     chain4;
      int                     i;
      odd_even = graphics_mode[4];
      off = addr[15:0];
      if (misc_control[3]) off[15] = 1'b0;
      if (is_write == MODE_READ) begin
        idx = chained(off, addr);
        plane = read_plane;
        if (odd_even) plane[0] = plane[0] | addr[0];
        latches = planes[idx];
        reads++;
        return latches[8*plane +: 8];
      end
      writes++;
      chain4 = memory_mode[3];
      wmode  = graphics_mode[1:0];
      op     = rotate_and_logic[4:3];
      idx = chain4 ? {off[15:2], 2'b00} : chained(off, addr);
      if (wmode == WMODE_ROTATE) begin
        doubled = {data, data} >> rotate_and_logic[2:0];
        data = doubled[7:0];
      end
      word = planes[idx];
      for (i = 0; i < Planes; i++) begin
        latch = latches[8*i +: 8];
        if (!write_mask[i]) continue;
        if (odd_even && i[0] != off[0]) continue;
        if (chain4 && i[1:0] != off[1:0]) continue;
        if (wmode == WMODE_NONE) continue;
        if (wmode == WMODE_LATCH) begin
          res = latch;
        end else begin
          if (wmode == WMODE_ROTATE) pd = set_reset[4+i] ? {8{set_reset[i]}} : data;
          else pd = {8{data[i]}};
          case (op)
            LOGIC_AND: pd &= latch;
            LOGIC_OR:  pd |= latch;
            LOGIC_XOR: pd ^= latch;
            default: ;
          endcase
          res = (pd & bit_mask) | (latch & ~bit_mask);
        end
        word[8*i +: 8] = res;
      end
      planes[idx] = word;
      return 8'h00;
    endfunction

    function void note_access(bit is_write, bit [AddrW-1:0] addr, bit [7:0] data);
      expected_bytes.push_back(predict_access(is_write, addr, data));
    endfunction

    function void check_byte(logic [7:0] got);
      bit [7:0] want;
      if (expected_bytes.size() == 0) begin
        $error("read_data: beat with no access pending, got %02h", got);
        errors++;
        return;
      end
      want = expected_bytes.pop_front();
      if (got !== want) begin
        $error("read_data mismatch: expected %02h, got %02h", want, got);
        errors++;
      end
    endfunction
  endclass

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we;
  logic [CfgIdxW-1:0]  cfg_idx;
  logic [CfgDataW-1:0] cfg_data;

  vpma_req_if req_if ();
  vpma_rsp_if rsp_if ();

  vga_planar_memory_access #(
    .PLANE_ADDR_BITS(PlaneAddrBits)
  ) u_top (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_we),
    .cfg_idx_i (cfg_idx),
    .cfg_data_i(cfg_data),
    .req_i     (req_if),
    .rsp_o     (rsp_if)
  );

  plane_scoreboard sb;
  bit              send_burst;
  bit              recv_burst;
  int              settings_count;
  int              quiet_cycles;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (rsp_if.valid && rsp_if.ready) sb.check_byte(rsp_if.read_data);
      if (req_if.valid && req_if.ready) begin
        sb.note_access(req_if.mode, req_if.host_address, req_if.write_data);
      end
    end
    if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= WatchdogLimit) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    int stall;
    rsp_if.ready = 1'b0;
    wait (rst_ni);
    @(negedge clk_i);
    forever begin
      stall = recv_burst ? 0 : $urandom_range(0, 14);
      if (stall > 0) begin
        rsp_if.ready <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      rsp_if.ready <= 1'b1;
      @(posedge clk_i);
      while (!rsp_if.valid) @(posedge clk_i);
      @(negedge clk_i);
    end
  end

  task automatic send_access(logic mode, logic [AddrW-1:0] addr, logic [7:0] data);
    int gap;
    gap = send_burst ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    req_if.valid        <= 1'b1;
    req_if.mode         <= mode;
    req_if.host_address <= addr;
    req_if.write_data   <= data;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic settle();
    req_if.valid <= 1'b0;
    while (sb.expected_bytes.size() != 0) @(negedge clk_i);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] value);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= value;
    @(negedge clk_i);
    cfg_we <= 1'b0;
    @(negedge clk_i);
    sb.set_register(idx, value);
  endtask

  task automatic apply_settings(logic [7:0] misc, logic [7:0] gmode, logic [7:0] rplane,
                                logic [7:0] ral, logic [7:0] srae, logic [7:0] bmask,
                                logic [7:0] pwm, logic [7:0] mmode);
    settle();
    write_reg(CFG_MISC_CONTROL, misc);
    write_reg(CFG_GRAPHICS_MODE, gmode);
    write_reg(CFG_READ_PLANE, rplane);
    write_reg(CFG_ROTATE_AND_LOGIC, ral);
    write_reg(CFG_SET_RESET, srae);
    write_reg(CFG_BIT_MASK, bmask);
    write_reg(CFG_PLANE_WRITE_MASK, pwm);
    write_reg(CFG_MEMORY_MODE, mmode);
    settings_count++;
  endtask

  function automatic logic [AddrW-1:0] pick_address();
    logic [AddrW-1:0] addr;
    addr = AddrW'($urandom_range(0, (1 << AddrW) - 1));
    if ($urandom_range(0, 3) != 0) addr[14:2] = 13'($urandom_range(0, 7));
    return addr;
  endfunction

  initial begin
    logic [AddrW-1:0] addr;
    int               beats;
    int               ph;
    sb = new();
    cfg_we              = 1'b0;
    cfg_idx             = '0;
    cfg_data            = '0;
    req_if.valid        = 1'b0;
    req_if.mode         = MODE_READ;
    req_if.host_address = '0;
    req_if.write_data   = '0;
    rst_ni              = 1'b0;
    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;

    send_access(MODE_WRITE, 20'h00000, 8'hFF);
    send_access(MODE_READ, 20'h00000, 8'h00);
    send_access(MODE_WRITE, 20'hFFFFF, 8'h00);
    send_access(MODE_READ, 20'hFFFFF, 8'hFF);
    send_access(MODE_WRITE, 20'h00001, 8'hA5);

    apply_settings(8'h00, {3'b000, 1'b1, 2'b00, WMODE_ROTATE}, 8'd1,
                   {3'b000, LOGIC_AND, 3'd3}, 8'h5A, 8'h0F, 8'h0F, 8'h00);
    send_access(MODE_READ, 20'h00001, 8'h00);
    send_access(MODE_WRITE, 20'h00001, 8'h3C);
    send_access(MODE_READ, 20'h00000, 8'h00);

    apply_settings(8'h02, {6'd0, WMODE_LATCH}, 8'd2,
                   {3'b000, LOGIC_OR, 3'd0}, 8'h00, 8'hFF, 8'h0F, 8'h08);
    send_access(MODE_READ, 20'h10002, 8'h00);
    send_access(MODE_WRITE, 20'h00007, 8'h11);
    send_access(MODE_READ, 20'h00004, 8'h00);

    apply_settings(8'h0A, {6'd0, WMODE_EXPAND}, 8'd0,
                   {3'b000, LOGIC_XOR, 3'd5}, 8'hF0, 8'hC3, 8'h0F, 8'h00);
    send_access(MODE_READ, 20'h18001, 8'h00);
    send_access(MODE_WRITE, 20'h08003, 8'h96);
    send_access(MODE_READ, 20'h08002, 8'h00);

    apply_settings(8'hFF, 8'hFF, 8'd3, 8'h1F, 8'hFF, 8'h00, 8'h00, 8'hFF);
    send_access(MODE_WRITE, 20'h12345, 8'h5A);
    send_access(MODE_READ, 20'h12345, 8'h00);

    apply_settings(8'h00, {6'd0, WMODE_ROTATE}, 8'd3,
                   {3'b000, LOGIC_COPY, 3'd1}, 8'hF5, 8'hFF, 8'h0A, 8'h00);
    send_access(MODE_WRITE, 20'h7FFFF, 8'h81);
    send_access(MODE_READ, 20'h7FFFF, 8'h00);

    for (ph = 0; ph < RandomPhases; ph++) begin
      if (ph == 0) begin
        apply_settings(8'h00, 8'h00, 8'd0, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
      end else if (ph == 1) begin
        apply_settings(8'hFF, 8'hFF, 8'd3, 8'h1F, 8'hFF, 8'hFF, 8'h0F, 8'hFF);
      end else begin
        apply_settings(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                       8'($urandom_range(0, 3)), 8'($urandom_range(0, 31)),
                       8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                       8'($urandom_range(0, 15)), 8'($urandom_range(0, 255)));
      end
      send_burst = (ph % 4 == 1) || (ph % 4 == 3);
      recv_burst = (ph % 4 == 2) || (ph % 4 == 3);
      beats = 0;
      while (beats < PhaseBeats) begin
        addr = pick_address();
        if ($urandom_range(0, 9) < 7) begin
          send_access(MODE_READ, addr, 8'($urandom_range(0, 255)));
          send_access(MODE_WRITE, addr, 8'($urandom_range(0, 255)));
          send_access(MODE_READ, addr, 8'($urandom_range(0, 255)));
          beats += 3;
        end else begin
          send_access(1'($urandom_range(0, 1)), addr, 8'($urandom_range(0, 255)));
          beats++;
        end
      end
    end

    settle();
    repeat (20) @(negedge clk_i);
    if (sb.expected_bytes.size() != 0) begin
      $error("read_data: %0d expected beats never arrived", sb.expected_bytes.size());
      sb.errors++;
    end
    $display("Run covered %0d reads and %0d writes under %0d register settings,",
             sb.reads, sb.writes, settings_count);
    $display("with random gaps and stalls on both channels and some back-to-back phases.");
    if (sb.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
